// ----- sv/srig_pkg.sv -----
// ----------------------------------------------------------------------------
// srig_pkg
// shared widths, limits and the control word of the reversing cell chain
// ----------------------------------------------------------------------------
package srig_pkg;

  localparam int MAX_GROUP = 16;
  localparam int VALUE_W   = 32;
  localparam int IDX_W     = $clog2(MAX_GROUP);
  localparam int CNT_W     = $clog2(MAX_GROUP + 1);
  localparam int CFG_W     = 5;

  localparam logic [CFG_W-1:0] GROUP_RESET = CFG_W'(3);

  // per-cycle movement of the chain, same for every cell
  typedef struct packed {
    logic shift_up;    // cell i takes cell i-1, cell 0 takes the new request
    logic shift_down;  // cell i takes cell i+1
  } chain_ctl_t;

  // zero reads as one, anything above the chain length saturates
  function automatic logic [CNT_W-1:0] eff_group(input logic [CFG_W-1:0] size);
    logic [CNT_W-1:0] k;
    if (size == '0) begin
      k = CNT_W'(1);
    end else if (CNT_W'(size) > CNT_W'(MAX_GROUP) || size > CFG_W'(MAX_GROUP)) begin
      k = CNT_W'(MAX_GROUP);
    end else begin
      k = CNT_W'(size);
    end
    return k;
  endfunction

endpackage

// ----- sv/srig_cell.sv -----
// ----------------------------------------------------------------------------
// srig_cell
// one slot of the group buffer; moves its value up or down the chain
// ----------------------------------------------------------------------------
module srig_cell
  import srig_pkg::*;
(
  input  logic                      clk,
  input  chain_ctl_t                ctl,
  input  logic signed [VALUE_W-1:0] from_lower,
  input  logic signed [VALUE_W-1:0] from_upper,
  output logic signed [VALUE_W-1:0] value
);

  logic signed [VALUE_W-1:0] value_next;

  always_comb begin
    priority if (ctl.shift_up) begin
      value_next = from_lower;
    end else if (ctl.shift_down) begin
      value_next = from_upper;
    end else begin
      value_next = value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ----- sv/stream_reverse_in_groups.sv -----
// ----------------------------------------------------------------------------
// stream_reverse_in_groups
// buffers a value stream and sends each full group back newest first
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries item_value and end_of_stream. Each
// request is pushed into a 16-cell chain. Once the chain holds group_size
// requests, the whole group is sent newest first; a partial group closed by
// end_of_stream is sent oldest first. Only these requests produce results;
// last_of_run marks the final result of each run.
// Output channel out_valid/out_stall carries out_value and last_of_run from
// one output register. One request is taken per cycle while a group fills,
// then one result per cycle while it drains and the receiver does not stall.
// A run's first result is registered once the drain state is entered and
// the output register is free. in_stall is high while a run drains. A
// stalled receiver freezes the drain; the last result may wait in the output
// register while new requests are taken. Reset (rst, synchronous) empties
// the buffer and sets group_size to 3; cfg_write loads group_size from
// cfg_data. Write only while the block is idle; the block does not check it.
// ----------------------------------------------------------------------------
module stream_reverse_in_groups
  import srig_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VALUE_W-1:0] item_value,
  input  logic                      end_of_stream,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                      last_of_run,
  input  logic                      cfg_write,
  input  logic [CFG_W-1:0]          cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_REV,
    S_FWD
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     fill;
  logic [CNT_W-1:0]     remaining;
  logic [IDX_W-1:0]     tap;
  logic [CFG_W-1:0]     group_size;

  logic                      accept;
  logic                      out_free;
  logic                      emit;
  logic [CNT_W-1:0]          fill_inc;
  logic [CNT_W-1:0]          k;
  chain_ctl_t                ctl;
  logic signed [VALUE_W-1:0] cell_q [MAX_GROUP];
  logic signed [VALUE_W-1:0] tap_value;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign emit     = (state != S_IDLE) && out_free;
  assign fill_inc = fill + CNT_W'(1);
  assign k        = eff_group(group_size);

  assign ctl.shift_up   = accept || (emit && state == S_FWD);
  assign ctl.shift_down = emit && (state == S_REV);

  // newest sits in cell 0; a forward drain keeps the oldest at a fixed tap
  assign tap_value = (state == S_REV) ? cell_q[0] : cell_q[tap];

  for (genvar i = 0; i < MAX_GROUP; i++) begin : g_chain
    logic signed [VALUE_W-1:0] lower;
    logic signed [VALUE_W-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = item_value;
    end else begin : g_mid_lo
      assign lower = cell_q[i-1];
    end
    if (i == MAX_GROUP - 1) begin : g_last
      assign upper = cell_q[i];
    end else begin : g_mid_hi
      assign upper = cell_q[i+1];
    end
    srig_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .from_lower (lower),
      .from_upper (upper),
      .value      (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      remaining  <= '0;
      tap        <= '0;
      out_valid  <= 1'b0;
      group_size <= GROUP_RESET;
    end else begin
      if (cfg_write) begin
        group_size <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (fill_inc >= k) begin
              state     <= S_REV;
              remaining <= fill_inc;
              fill      <= '0;
            end else if (end_of_stream) begin
              state     <= S_FWD;
              remaining <= fill_inc;
              tap       <= fill[IDX_W-1:0];
              fill      <= '0;
            end else begin
              fill <= fill_inc;
            end
          end
        end
        S_REV, S_FWD: begin
          if (emit) begin
            remaining <= remaining - CNT_W'(1);
            if (remaining == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value   <= tap_value;
      last_of_run <= (remaining == CNT_W'(1));
    end
  end

  a_idle_empty_run: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> remaining == '0 && fill < CNT_W'(MAX_GROUP))
    else $error("idle with a run pending or buffer overfull");

  a_final_result: assert property (@(posedge clk) disable iff (rst)
    emit && remaining == CNT_W'(1) |=> out_valid && last_of_run && state == S_IDLE)
    else $error("final result of a run not marked");

  a_mid_result: assert property (@(posedge clk) disable iff (rst)
    emit && remaining != CNT_W'(1) |=> out_valid && !last_of_run && state != S_IDLE)
    else $error("run ended early");

  a_partial_holds: assert property (@(posedge clk) disable iff (rst)
    accept && !end_of_stream && fill_inc < k && !cfg_write |=> state == S_IDLE &&
      fill == $past(fill_inc))
    else $error("partial group did not stay buffered");

endmodule

// ----- tb/stream_reverse_in_groups_tb.sv -----
// ----------------------------------------------------------------------------
// stream_reverse_in_groups_tb
// drives value streams through the group reverser and checks every result
// against a cycle-free model of the reordering, under random idling on both
// channels, group size changes and one long receiver hold-off
// ----------------------------------------------------------------------------
module stream_reverse_in_groups_tb
  import srig_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               last;
  } reordered_t;

  logic                      clk           = 1'b0;
  logic                      rst           = 1'b1;
  logic                      in_valid      = 1'b0;
  logic                      in_stall;
  logic signed [VALUE_W-1:0] item_value    = '0;
  logic                      end_of_stream = 1'b0;
  logic                      out_valid;
  logic                      out_stall     = 1'b0;
  logic signed [VALUE_W-1:0] out_value;
  logic                      last_of_run;
  logic                      cfg_write     = 1'b0;
  logic [CFG_W-1:0]          cfg_data      = '0;

  // model state
  logic [VALUE_W-1:0] held_vals [MAX_GROUP];
  int                 held_count = 0;
  logic [CFG_W-1:0]   group_cfg  = GROUP_RESET;
  reordered_t         reordered_q [$];

  int mismatch_count = 0;
  bit tx_idle_on     = 1'b1;
  bit rx_idle_on     = 1'b1;
  int rx_hold_cycles = 0;

  stream_reverse_in_groups u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .item_value    (item_value),
    .end_of_stream (end_of_stream),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .last_of_run   (last_of_run),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // append one expected result at the tail
  function automatic void queue_expected(reordered_t r);
    reordered_q.insert(reordered_q.size(), r);
  endfunction

  function automatic void predict_reorder(logic [VALUE_W-1:0] v, logic eos);
    int k;
    reordered_t r;
    if (group_cfg == '0) begin
      k = 1;
    end else if (group_cfg > CFG_W'(MAX_GROUP)) begin
      k = MAX_GROUP;
    end else begin
      k = int'(group_cfg);
    end
    if (held_count >= MAX_GROUP) begin
      held_count = 0;
    end
    held_vals[held_count] = v;
    held_count++;
    if (held_count >= k) begin
      // full group, newest first
      for (int i = 0; i < held_count; i++) begin
        r.value = held_vals[held_count - 1 - i];
        r.last  = (i + 1 == held_count);
        queue_expected(r);
      end
      held_count = 0;
    end else if (eos) begin
      // stream closed on a partial group, arrival order
      for (int i = 0; i < held_count; i++) begin
        r.value = held_vals[i];
        r.last  = (i + 1 == held_count);
        queue_expected(r);
      end
      held_count = 0;
    end
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = {1'b1, {(VALUE_W-1){1'b0}}};
      1: v = {1'b0, {(VALUE_W-1){1'b1}}};
      2: v = '0;
      3: v = '1;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [VALUE_W-1:0] got,
                                 logic [VALUE_W-1:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // called just after a rising edge; returns at the edge that takes the request
  task automatic send_item(logic [VALUE_W-1:0] v, logic eos);
    int gap;
    gap = 0;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    item_value    <= v;
    end_of_stream <= eos;
    do @(posedge clk); while (in_stall);
    predict_reorder(v, eos);
  endtask

  task automatic send_stream(int len);
    for (int i = 0; i < len; i++) begin
      send_item(rand_value(), i == len - 1);
    end
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (reordered_q.size() != 0) @(posedge clk);
    // a request with no result may still be settling in the chain
    repeat (8) @(posedge clk);
  endtask

  task automatic write_group_size(logic [CFG_W-1:0] v);
    wait_results_drained();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    group_cfg = v;
  endtask

  // receiver side: long hold when asked, else random stall bursts unless idling is off
  initial begin : rx_stall_gen
    int  run_left;
    bit  stall_now;
    run_left  = 0;
    stall_now = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_stall <= 1'b1;
      end else if (!rx_idle_on) begin
        out_stall <= 1'b0;
      end else begin
        if (run_left == 0) begin
          stall_now = ($urandom_range(0, 2) == 0);
          run_left  = $urandom_range(1, 18);
        end
        run_left--;
        out_stall <= stall_now;
      end
    end
  end

  always @(posedge clk) begin : result_check
    reordered_t want;
    if (!rst && out_valid && !out_stall) begin
      if (reordered_q.size() == 0) begin
        report_mismatch("result with nothing pending", out_value, '0);
      end else begin
        want = reordered_q.pop_front();
        if (out_value !== want.value) begin
          report_mismatch("out_value", out_value, want.value);
        end
        if (last_of_run !== want.last) begin
          report_mismatch("last_of_run", VALUE_W'(last_of_run), VALUE_W'(want.last));
        end
      end
    end
  end

  // group size of three from reset: full groups, partial close, close on a full group
  task automatic test_reset_group();
    send_item({1'b1, {(VALUE_W-1){1'b0}}}, 1'b0);
    send_item({1'b0, {(VALUE_W-1){1'b1}}}, 1'b0);
    send_item('0, 1'b0);
    send_item('1, 1'b0);
    send_item(32'h0000_0005, 1'b1);
    send_item(32'h0000_0007, 1'b0);
    send_item(32'hdead_beef, 1'b0);
    send_item(32'h1234_5678, 1'b1);
  endtask

  // zero reads as one, one passes through, oversize saturates
  task automatic test_group_edges();
    write_group_size(CFG_W'(0));
    send_item(32'h8000_0001, 1'b0);
    send_item(32'h7fff_fffe, 1'b1);
    write_group_size(CFG_W'(1));
    send_item(32'ha5a5_a5a5, 1'b0);
    write_group_size(CFG_W'(31));
    send_item(32'h0000_0001, 1'b0);
    send_item(32'hffff_fffe, 1'b0);
    send_item(32'h5a5a_5a5a, 1'b1);
  endtask

  // smaller size written while a partial group is held
  task automatic test_lowered_group();
    write_group_size(CFG_W'(8));
    send_item(32'h0000_0011, 1'b0);
    send_item(32'h0000_0022, 1'b0);
    send_item(32'h0000_0033, 1'b0);
    send_item(32'h0000_0044, 1'b0);
    write_group_size(CFG_W'(2));
    send_item(32'h0000_0055, 1'b0);
  endtask

  // receiver holds off while the sender keeps offering requests
  task automatic test_backpressure();
    write_group_size(CFG_W'(MAX_GROUP));
    tx_idle_on     = 1'b0;
    rx_hold_cycles = 300;
    for (int i = 0; i < 40; i++) begin
      send_item(rand_value(), i == 39 || i == 31);
    end
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_streams();
    int               sent;
    int               len;
    logic [CFG_W-1:0] sz;
    sent = 0;
    while (sent < 300) begin
      case ($urandom_range(0, 9))
        0:       sz = '0;
        1:       sz = CFG_W'($urandom_range(MAX_GROUP + 1, 31));
        2:       sz = CFG_W'(MAX_GROUP);
        3:       sz = CFG_W'($urandom_range(7, MAX_GROUP - 1));
        default: sz = CFG_W'($urandom_range(1, 6));
      endcase
      write_group_size(sz);
      // quiet channels for the closing stretch
      if (sent >= 250) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      repeat ($urandom_range(2, 5)) begin
        if ($urandom_range(0, 7) == 0) begin
          send_item(rand_value(), 1'($urandom_range(0, 1)));
          sent++;
        end else begin
          len = $urandom_range(1, 20);
          send_stream(len);
          sent += len;
        end
      end
    end
  endtask

  initial begin : main_seq
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_group();
    test_group_edges();
    test_lowered_group();
    test_backpressure();
    test_random_streams();
    wait_results_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("stream_reverse_in_groups_tb OK");
    end else begin
      $display("stream_reverse_in_groups_tb NOT OK");
    end
    $finish;
  end

  initial begin : run_limit
    #2_000_000;
    $display("stream_reverse_in_groups_tb NOT OK");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/srig_pkg.sv
sv/srig_cell.sv
sv/stream_reverse_in_groups.sv
tb/stream_reverse_in_groups_tb.sv
